// File: sv/bitplane_popcount_dot_product_defines.svh
// Assertion macros shared by the bit-plane popcount dot product RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef BITPLANE_POPCOUNT_DOT_PRODUCT_DEFINES_SVH
`define BITPLANE_POPCOUNT_DOT_PRODUCT_DEFINES_SVH

// same-cycle implication, off while in reset
`define BPPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define BPPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bppd_pkg.sv
// Shared types, widths, codes and helpers for the bit-plane popcount dot product.
// No dependencies.
package bppd_pkg;

    localparam int DATA_W          = 64;
    localparam int NUM_PLANE_INPUTS = 8;
    localparam int BYTES_PER_WORD  = DATA_W / 8;
    localparam int VB_W            = 4;
    localparam int BCNT_W          = 4;   // popcount of one byte, 0..8
    localparam int CNT_W           = 7;   // popcount of one word, 0..64
    localparam int WSUM_W          = 14;  // weighted word sum, up to 64*255
    localparam int SUM_W           = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int MAX_PLANES_DEF  = 8;

    localparam int IN_TDATA_W  = 584;  // 9 words + valid_bytes, padded to bytes
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 2'd1;

    localparam logic [1:0] MODE_AND = 2'd0;
    localparam logic [1:0] MODE_XOR = 2'd1;
    localparam logic [1:0] MODE_POP = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    function automatic logic [BCNT_W-1:0] pop8(input logic [7:0] b);
        logic [BCNT_W-1:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + BCNT_W'(b[k]);
        end
        return c;
    endfunction

endpackage

// File: sv/bppd_popcnt.sv
// Masking and per-plane word popcount lanes, one registered stage.
// Depends on bppd_pkg.
module bppd_popcnt #(
    parameter int MAX_PLANES = bppd_pkg::MAX_PLANES_DEF
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_adv,
    input  bppd_pkg::t_stage_ctl                                    i_ctl,
    input  logic [bppd_pkg::DATA_W-1:0]                             i_data,
    input  logic [bppd_pkg::NUM_PLANE_INPUTS-1:0][bppd_pkg::DATA_W-1:0] i_planes,
    input  logic [bppd_pkg::VB_W-1:0]                               i_valid_bytes,
    input  logic [1:0]                                              i_op_mode,
    input  logic [3:0]                                              i_plane_count,
    output bppd_pkg::t_stage_ctl                                    o_ctl,
    output logic [MAX_PLANES-1:0][bppd_pkg::CNT_W-1:0]              o_cnt
);
    import bppd_pkg::*;

    t_stage_ctl                         r_ctl;
    logic [MAX_PLANES-1:0][CNT_W-1:0]   r_cnt;
    logic [MAX_PLANES-1:0][CNT_W-1:0]   n_cnt;
    logic [BYTES_PER_WORD-1:0]          byte_ok;

    always_comb begin
        for (int b = 0; b < BYTES_PER_WORD; b++) begin
            byte_ok[b] = (i_valid_bytes > VB_W'(b));
        end
    end

    for (genvar j = 0; j < MAX_PLANES; j++) begin : g_lane
        logic [DATA_W-1:0] word;
        logic              active;

        always_comb begin
            unique case (i_op_mode)
                MODE_AND: begin
                    word   = i_planes[j] & i_data;
                    active = (i_plane_count > 4'(j));
                end
                MODE_XOR: begin
                    word   = i_planes[j] ^ i_data;
                    active = (i_plane_count > 4'(j));
                end
                MODE_POP: begin
                    word   = i_data;
                    active = (j == 0);
                end
                default: begin
                    word   = '0;
                    active = 1'b0;
                end
            endcase
        end

        always_comb begin
            n_cnt[j] = '0;
            for (int b = 0; b < BYTES_PER_WORD; b++) begin
                if (byte_ok[b] && active) begin
                    n_cnt[j] = n_cnt[j] + CNT_W'(pop8(word[8*b +: 8]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_ctl = r_ctl;
    assign o_cnt = r_cnt;

endmodule

// File: sv/bppd_accum.sv
// Plane weighting stage, saturating accumulator and result register.
// Depends on bppd_pkg and the assertion macro header.
`include "bitplane_popcount_dot_product_defines.svh"

module bppd_accum #(
    parameter int MAX_PLANES = bppd_pkg::MAX_PLANES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_adv,
    input  bppd_pkg::t_stage_ctl                         i_ctl,
    input  logic [MAX_PLANES-1:0][bppd_pkg::CNT_W-1:0]   i_cnt,
    output logic                                         o_valid,
    output logic [bppd_pkg::SUM_W-1:0]                   o_sum
);
    import bppd_pkg::*;

    t_stage_ctl         r_w_ctl;
    logic [WSUM_W-1:0]  r_wsum;
    logic [WSUM_W-1:0]  n_wsum;
    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   n_sat;
    logic [SUM_W:0]     total;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;

    // plane j carries weight 2^j
    always_comb begin
        n_wsum = '0;
        for (int j = 0; j < MAX_PLANES; j++) begin
            n_wsum = n_wsum + (WSUM_W'(i_cnt[j]) << j);
        end
    end

    assign total = (SUM_W+1)'(r_acc) + (SUM_W+1)'(r_wsum);
    assign n_sat = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_ctl     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_w_ctl     <= i_ctl;
            r_out_valid <= r_w_ctl.valid & r_w_ctl.last;
            if (r_w_ctl.valid) begin
                r_acc <= r_w_ctl.last ? '0 : n_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wsum <= n_wsum;
            if (r_w_ctl.valid && r_w_ctl.last) begin
                r_out_sum <= n_sat;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;

    `BPPD_ASSERT_NEXT(a_acc_clear, i_rst_n && i_adv && r_w_ctl.valid && r_w_ctl.last, r_acc == '0, "accumulator not cleared after last word")
    `BPPD_ASSERT_NEXT(a_acc_grow, i_rst_n && i_adv && r_w_ctl.valid && !r_w_ctl.last, r_acc >= $past(r_acc), "accumulator decreased mid-vector")
    `BPPD_ASSERT_NEXT(a_stall_hold, i_rst_n && !i_adv, $stable(r_acc) && $stable(r_out_sum) && $stable(r_w_ctl), "state moved during stall")
    `BPPD_ASSERT_NEXT(a_out_src, i_rst_n && i_adv, r_out_valid == $past(r_w_ctl.valid && r_w_ctl.last), "result without a last word")

endmodule

// File: sv/bitplane_popcount_dot_product.sv
// Bit-plane popcount dot product: takes one 64-bit code word per cycle with up to
// eight query plane words, accumulates the weighted popcount and emits the saturated
// sum on the last word of each vector. A transfer is taken every cycle the result
// side is not stalled; the sum for a vector then passes the input register, the
// popcount lanes, plane weighting and the accumulator/result register in order.
// The eight parallel 64-bit popcount lanes allow one word per cycle when not stalled.
// Configuration (op_mode, plane_count) is written through the cfg channel, which is
// always ready and should only be used while no vector is in flight.
// Depends on bppd_pkg, bppd_popcnt, bppd_accum.
module bitplane_popcount_dot_product #(
    parameter int MAX_PLANES = bppd_pkg::MAX_PLANES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cfg write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bppd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bppd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [63:0] data_word, [64*(j+1)+63:64*(j+1)] query_plane_j (j=0..7),
    // [579:576] valid_bytes, [583:580] zero
    input  logic [bppd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,   // last_word
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [22:0] dot_sum, [23] zero
    output logic [bppd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bppd_pkg::*;

    logic                                       adv;
    logic [1:0]                                 r_op_mode;
    logic [3:0]                                 r_plane_count;
    t_stage_ctl                                 r_in_ctl;
    logic [DATA_W-1:0]                          r_in_data;
    logic [NUM_PLANE_INPUTS-1:0][DATA_W-1:0]    r_in_planes;
    logic [VB_W-1:0]                            r_in_vb;
    t_stage_ctl                                 pc_ctl;
    logic [MAX_PLANES-1:0][CNT_W-1:0]           pc_cnt;
    logic                                       out_valid;
    logic [SUM_W-1:0]                           out_sum;

    // whole pipeline moves together unless the result register is held
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode     <= MODE_AND;
            r_plane_count <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OP_MODE:     r_op_mode     <= i_cfg_data[1:0];
                CFG_PLANE_COUNT: r_plane_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (adv) begin
            r_in_ctl.valid <= s_axis_tvalid;
            r_in_ctl.last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_data <= s_axis_tdata[DATA_W-1:0];
            for (int j = 0; j < NUM_PLANE_INPUTS; j++) begin
                r_in_planes[j] <= s_axis_tdata[DATA_W*(j+1) +: DATA_W];
            end
            r_in_vb <= s_axis_tdata[DATA_W*(NUM_PLANE_INPUTS+1) +: VB_W];
        end
    end

    bppd_popcnt #(
        .MAX_PLANES (MAX_PLANES)
    ) u_popcnt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_ctl         (r_in_ctl),
        .i_data        (r_in_data),
        .i_planes      (r_in_planes),
        .i_valid_bytes (r_in_vb),
        .i_op_mode     (r_op_mode),
        .i_plane_count (r_plane_count),
        .o_ctl         (pc_ctl),
        .o_cnt         (pc_cnt)
    );

    bppd_accum #(
        .MAX_PLANES (MAX_PLANES)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (pc_ctl),
        .i_cnt   (pc_cnt),
        .o_valid (out_valid),
        .o_sum   (out_sum)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-SUM_W){1'b0}}, out_sum};

endmodule
